[hw/rtl/five_source_priority_interrupt_ctrl_core_assert.svh]
// Assertion macros for the five-source interrupt controller.
// Needs clk and rst_n in the scope of use.
`ifndef FIVE_SOURCE_PRIORITY_INTERRUPT_CTRL_CORE_ASSERT_SVH
`define FIVE_SOURCE_PRIORITY_INTERRUPT_CTRL_CORE_ASSERT_SVH

// Condition holds at every edge out of reset.
`define PIC5_ASSERT_NOW(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("pic5 check failed");

// Consequent holds in the cycle after the antecedent.
`define PIC5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pic5 check failed");

`endif

[hw/rtl/pic5_pkg.sv]
// Shared types and constants for the five-source interrupt controller.
// No dependencies.
`timescale 1ns / 1ps

package pic5_pkg;

  localparam int NUM_SRC = 5;

  typedef enum logic [1:0] {
    MODE_LINE = 2'd0,
    MODE_MASK = 2'd1,
    MODE_ACK  = 2'd2,
    MODE_EOI  = 2'd3
  } mode_t;

  localparam logic [7:0] NO_VECTOR = 8'hff;
  localparam logic [7:0] VEC_BASE  = 8'hf0;
  localparam int         SUB_BIT   = 7;

  // Enable-byte bit of each source, in priority order (0x10, 0x01, 0x02, 0x04, 0x08).
  localparam logic [2:0] SRC_BIT_IDX [NUM_SRC] = '{3'd4, 3'd0, 3'd1, 3'd2, 3'd3};

  // Per-cell strobes and enable bits for one request.
  typedef struct packed {
    logic line_we;
    logic line_val;
    logic ack;
    logic eoi;
    logic pend_clr;
    logic en_cur;
    logic en_nxt;
  } cell_ctl_t;

  // Token passed from a higher-priority cell to the next one down.
  typedef struct packed {
    logic ack_taken;
    logic eoi_done;
  } chain_t;

endpackage

[hw/rtl/five_source_priority_interrupt_ctrl_core.sv]
// Five-source vectored interrupt controller with fixed priority 0x10, 0x01, 0x02, 0x04, 0x08.
// Takes one request per clock unless a held result is not yet taken, and returns each result
// in the next cycle from an output register; the five-cell priority chain is combinational.
// Depends on pic5_pkg, pic5_cell and the assertion header.
`timescale 1ns / 1ps

`include "five_source_priority_interrupt_ctrl_core_assert.svh"

module five_source_priority_interrupt_ctrl_core import pic5_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [2:0] in_source,
  input  logic [7:0] in_value,
  input  logic [7:0] in_line_mask,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_irq_level,
  output logic [7:0] out_vector_out,
  output logic       out_sub_signal_change,
  output logic       out_sub_signal_level
);

  // Request modes:
  //   line change  - set or clear one pending bit from value AND line_mask
  //   mask write   - load the enable byte; any change of bit 7 goes to the sub CPU,
  //                  and a rising bit 7 drops pending on the top source
  //   acknowledge  - highest qualifying source moves to service, vector F0..F8
  //   end of int.  - clear the highest-priority in-service bit
  // irq_level always reflects the state after the request.

  logic       accept;
  mode_t      mode;
  logic [7:0] en_r, en_nxt;
  logic       line_val;
  logic       sub_rise;
  logic       sub_chg;
  logic       ack_grant;

  cell_ctl_t  ctl   [NUM_SRC];
  chain_t     chain [NUM_SRC+1];
  logic [NUM_SRC-1:0] grant;
  logic [NUM_SRC-1:0] qual_nxt;
  logic [7:0] vec;

  logic       out_valid_r;
  logic       irq_r;
  logic [7:0] vec_r;
  logic       chg_r;
  logic       lvl_r;

  // Output register frees the input side whenever the held result is taken.
  assign in_ready = ~out_valid_r | out_ready;
  assign accept   = in_valid & in_ready;
  assign mode     = mode_t'(in_mode);
  assign line_val = |(in_value & in_line_mask);

  always_comb begin
    en_nxt   = en_r;
    sub_rise = 1'b0;
    sub_chg  = 1'b0;
    if (accept && mode == MODE_MASK) begin
      en_nxt   = in_value;
      sub_rise = ~en_r[SUB_BIT] & in_value[SUB_BIT];
      sub_chg  = en_r[SUB_BIT] ^ in_value[SUB_BIT];
    end
  end

  assign chain[0] = '0;

  // Cell 0 is the highest priority; tokens ripple downwards.
  for (genvar g = 0; g < NUM_SRC; g++) begin : g_cell
    always_comb begin
      ctl[g].line_we  = accept && mode == MODE_LINE && in_source == 3'(g);
      ctl[g].line_val = line_val;
      ctl[g].ack      = accept && mode == MODE_ACK;
      ctl[g].eoi      = accept && mode == MODE_EOI;
      ctl[g].pend_clr = (g == 0) ? sub_rise : 1'b0;
      ctl[g].en_cur   = en_r[SRC_BIT_IDX[g]];
      ctl[g].en_nxt   = en_nxt[SRC_BIT_IDX[g]];
    end

    pic5_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[g]),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .grant     (grant[g]),
      .qual_nxt  (qual_nxt[g])
    );
  end

  // Grant is one-hot at most; vector is F0 + 2 * priority index.
  always_comb begin
    vec = NO_VECTOR;
    for (int i = 0; i < NUM_SRC; i++) begin
      if (grant[i]) begin
        vec = VEC_BASE + 8'(2 * i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      en_r <= en_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      irq_r <= |qual_nxt;
      vec_r <= vec;
      chg_r <= sub_chg;
      lvl_r <= en_nxt[SUB_BIT];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_irq_level         = irq_r;
  assign out_vector_out        = vec_r;
  assign out_sub_signal_change = chg_r;
  assign out_sub_signal_level  = lvl_r;

  assign ack_grant = accept && mode == MODE_ACK && (|grant);

  `PIC5_ASSERT_NOW(a_grant_onehot, $onehot0(grant))
  `PIC5_ASSERT_NEXT(a_ack_vector, ack_grant, out_valid && out_vector_out != NO_VECTOR)
  `PIC5_ASSERT_NEXT(a_noack_novec, accept && mode != MODE_ACK, out_vector_out == NO_VECTOR)
  `PIC5_ASSERT_NEXT(a_sub_level, accept, out_sub_signal_level == en_r[SUB_BIT])

endmodule

[hw/rtl/pic5_cell.sv]
// One source cell: pending and in-service bits plus its slot in the priority chain.
// Depends on pic5_pkg.
`timescale 1ns / 1ps

module pic5_cell import pic5_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  chain_t    chain_in,
  output chain_t    chain_out,
  output logic      grant,
  output logic      qual_nxt
);

  logic pend_r, pend_nxt;
  logic serv_r, serv_nxt;
  logic qual_cur;
  logic eoi_hit;

  assign qual_cur = pend_r & ctl.en_cur & ~serv_r;
  assign grant    = ctl.ack & qual_cur & ~chain_in.ack_taken;
  assign eoi_hit  = ctl.eoi & serv_r & ~chain_in.eoi_done;

  assign chain_out.ack_taken = chain_in.ack_taken | qual_cur;
  assign chain_out.eoi_done  = chain_in.eoi_done | serv_r;

  always_comb begin
    pend_nxt = pend_r;
    if (ctl.line_we) begin
      pend_nxt = ctl.line_val;
    end else if (ctl.pend_clr || grant) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    serv_nxt = serv_r;
    if (grant) begin
      serv_nxt = 1'b1;
    end else if (eoi_hit) begin
      serv_nxt = 1'b0;
    end
  end

  assign qual_nxt = pend_nxt & ctl.en_nxt & ~serv_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      serv_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      serv_r <= serv_nxt;
    end
  end

endmodule
